// ===== design/tac_pkg.sv =====
// ----------------------------------------------------------------------------
// tac_pkg: shared types and constants for triangle assembly and culling
// Widths of the fixed-point datapath, register codes, queue and result types.
// ----------------------------------------------------------------------------
package tac_pkg;

  // Fixed-point format of the clip coordinates
  localparam int FRACTION_BITS = 16;
  localparam int COORD_W       = 32;
  localparam int ID_W          = 16;
  localparam int SLOTS         = 3;

  // Rounding by 4 bits, w scaled down by 6 bits when large
  localparam int ROUND_SHIFT   = 4;
  localparam int W_SCALE_SHIFT = 6;
  localparam logic signed [COORD_W:0] ROUND_BIAS = 33'sd8;
  localparam logic [COORD_W-1:0] W_BIG_MASK = 32'hff00_0000;

  // Datapath widths
  localparam int XY_W   = COORD_W + 1 - ROUND_SHIFT;         // rounded x, y
  localparam int RW_W   = COORD_W + 1 - W_SCALE_SHIFT - ROUND_SHIFT + 1; // rounded w
  localparam int MUL_W  = XY_W + 1;                          // multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int D_W    = 2 * XY_W + 1 - FRACTION_BITS;      // difference of two products
  localparam int LO_W   = 22;                                // low part of a difference
  localparam int HI_W   = D_W - LO_W;
  localparam int ACC_W  = RW_W + D_W + 2;

  // Determinant sequencer
  localparam int STEP_W    = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd6;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRIMITIVE_MODE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CULL_ENABLE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CULL_FACE       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOCKWISE_FRONT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TWO_SIDED_LIGHT = 3'd4;

  localparam logic [1:0] MODE_LIST  = 2'd0;
  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_FAN   = 2'd2;

  localparam logic [1:0] CULL_FRONT = 2'd0;
  localparam logic [1:0] CULL_BACK  = 2'd1;
  localparam logic [1:0] CULL_BOTH  = 2'd2;

  typedef struct packed {
    logic [1:0] primitive_mode;
    logic       cull_enable;
    logic [1:0] cull_face;
    logic       clockwise_front;
    logic       two_sided_light;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
  } vertex_t;

  // One assembled triangle, vertices in triangle order
  typedef struct packed {
    vertex_t [SLOTS-1:0] v;
  } job_t;

  typedef struct packed {
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] second_id;
    logic [ID_W-1:0] third_id;
    logic            is_clockwise;
    logic            is_back_face;
    logic            is_culled;
    logic            use_back_colour;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_EMIT
  } back_state_t;

  // floor((v + 8) / 16), one bit wider so it cannot overflow
  function automatic logic signed [XY_W-1:0] rnd4(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W:0] t;
    t = (COORD_W+1)'(v) + ROUND_BIAS;
    return t[COORD_W:ROUND_SHIFT];
  endfunction

endpackage

// ===== design/triangle_assembly_and_cull_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_assembly_and_cull_unit: triangle assembly and face culling
// Vertices in, one winding-corrected triangle with facing flags out.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Accepted when       Payload
//  vertex    push / full        push & !full        start_primitive, vertex_id,
//                                                   clip_x, clip_y, clip_w
//  triangle  empty / pop        pop & !empty        ids and four flags
//  config    cfg_write          cfg_write           cfg_index, cfg_data
//
// A vertex is taken whenever the two-entry triangle queue has room.
// Each triangle passes through the determinant unit as load, seven steps on
// two shared 30x30 multipliers, and emit; the unit takes the next triangle
// from the queue only once it has emitted the last one.
// Reset (synchronous) empties the queue and the result register.
// A result waiting on the port stalls only the determinant unit; the front
// goes on assembling until the queue fills.
module triangle_assembly_and_cull_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                start_primitive,
  input  logic [tac_pkg::ID_W-1:0]            vertex_id,
  input  logic signed [tac_pkg::COORD_W-1:0]  clip_x,
  input  logic signed [tac_pkg::COORD_W-1:0]  clip_y,
  input  logic signed [tac_pkg::COORD_W-1:0]  clip_w,
  output logic                                empty,
  input  logic                                pop,
  output logic [tac_pkg::ID_W-1:0]            first_id,
  output logic [tac_pkg::ID_W-1:0]            second_id,
  output logic [tac_pkg::ID_W-1:0]            third_id,
  output logic                                is_clockwise,
  output logic                                is_back_face,
  output logic                                is_culled,
  output logic                                use_back_colour,
  input  logic                                cfg_write,
  input  logic [tac_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tac_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tac_pkg::*;

  cfg_t    cfg;
  vertex_t vertex;
  job_t    fq_data, qb_data;
  logic    fq_wr, qb_rd, q_full, q_empty, res_valid, accept;
  result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.primitive_mode  <= MODE_LIST;
      cfg.cull_enable     <= 1'b0;
      cfg.cull_face       <= CULL_BACK;
      cfg.clockwise_front <= 1'b0;
      cfg.two_sided_light <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PRIMITIVE_MODE:  cfg.primitive_mode  <= cfg_data;
        CFG_CULL_ENABLE:     cfg.cull_enable     <= cfg_data[0];
        CFG_CULL_FACE:       cfg.cull_face       <= cfg_data;
        CFG_CLOCKWISE_FRONT: cfg.clockwise_front <= cfg_data[0];
        CFG_TWO_SIDED_LIGHT: cfg.two_sided_light <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign accept    = push && !q_full;
  assign full      = q_full;
  assign vertex.id = vertex_id;
  assign vertex.x  = clip_x;
  assign vertex.y  = clip_y;
  assign vertex.w  = clip_w;

  tac_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .accept          (accept),
    .start_primitive (start_primitive),
    .vertex          (vertex),
    .q_wr            (fq_wr),
    .q_data          (fq_data)
  );

  tac_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_wr),
    .wr_data (fq_data),
    .rd_en   (qb_rd),
    .rd_data (qb_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  tac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (qb_data),
    .q_rd      (qb_rd),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  // result port
  assign empty           = !res_valid;
  assign first_id        = res.first_id;
  assign second_id       = res.second_id;
  assign third_id        = res.third_id;
  assign is_clockwise    = res.is_clockwise;
  assign is_back_face    = res.is_back_face;
  assign is_culled       = res.is_culled;
  assign use_back_colour = res.use_back_colour;

endmodule

// ===== design/tac_front.sv =====
// ----------------------------------------------------------------------------
// tac_front: vertex slots and primitive assembly
// Stores each accepted vertex and hands every triangle formed to the queue.
// ----------------------------------------------------------------------------
module tac_front (
  input  logic                        clk,
  input  logic                        rst,
  input  tac_pkg::cfg_t               cfg,
  input  logic                        accept,
  input  logic                        start_primitive,
  input  tac_pkg::vertex_t            vertex,
  output logic                        q_wr,
  output tac_pkg::job_t               q_data
);
  import tac_pkg::*;

  localparam logic [1:0] SLOT_LAST   = 2'd2;
  localparam logic [1:0] SLOT_FULL   = 2'd3;
  localparam logic [1:0] PHASE_EVEN  = 2'd2;
  localparam logic [1:0] PHASE_ODD   = 2'd3;

  vertex_t    slot [SLOTS];
  vertex_t    slot_new [SLOTS];
  logic [1:0] write_slot, write_slot_next;
  logic [1:0] assembly_phase, assembly_phase_next;
  logic [1:0] ws0, ph0, s, ws1;
  logic       tri_formed, swap_bc, chain;

  // assembly decisions for the incoming vertex
  always_comb begin
    ws0 = start_primitive ? 2'd0 : write_slot;
    ph0 = start_primitive ? 2'd0 : assembly_phase;
    s   = (ws0 > SLOT_LAST) ? 2'd0 : ws0;
    ws1 = s + 2'd1;
    chain = cfg.primitive_mode inside {MODE_STRIP, MODE_FAN};
    write_slot_next     = ws1;
    assembly_phase_next = ph0;
    tri_formed = 1'b0;
    swap_bc    = 1'b0;
    if (chain) begin
      if (ph0 == PHASE_ODD) begin
        tri_formed = 1'b1;
        swap_bc    = 1'b1;
        assembly_phase_next = PHASE_EVEN;
      end else if (ph0 == PHASE_EVEN) begin
        tri_formed = 1'b1;
        assembly_phase_next = PHASE_ODD;
      end else begin
        assembly_phase_next = ph0 + 2'd1;
      end
      if (ws1 == SLOT_FULL) begin
        write_slot_next = (cfg.primitive_mode == MODE_FAN) ? 2'd1 : 2'd0;
      end
    end else if (ws1 == SLOT_FULL) begin
      tri_formed = 1'b1;
      write_slot_next = 2'd0;
    end
  end

  // slots as they stand once this vertex is in
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_new[i] = (s == 2'(i)) ? vertex : slot[i];
    end
    q_data.v[0] = slot_new[0];
    q_data.v[1] = swap_bc ? slot_new[2] : slot_new[1];
    q_data.v[2] = swap_bc ? slot_new[1] : slot_new[2];
    q_wr = accept && tri_formed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot     <= 2'd0;
      assembly_phase <= 2'd0;
    end else if (accept) begin
      write_slot     <= write_slot_next;
      assembly_phase <= assembly_phase_next;
    end
  end

  // slot payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      slot[s] <= vertex;
    end
  end

endmodule

// ===== design/tac_queue.sv =====
// ----------------------------------------------------------------------------
// tac_queue: short triangle queue between assembly and the determinant unit
// Two entries, so assembly keeps taking vertices while a triangle is worked on.
// ----------------------------------------------------------------------------
module tac_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  tac_pkg::job_t  wr_data,
  input  logic           rd_en,
  output tac_pkg::job_t  rd_data,
  output logic           full,
  output logic           empty
);
  import tac_pkg::*;

  job_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== design/tac_back.sv =====
// ----------------------------------------------------------------------------
// tac_back: determinant sign, facing and culling
// Two shared multipliers step through the 3x3 determinant; result register out.
// ----------------------------------------------------------------------------
module tac_back (
  input  logic              clk,
  input  logic              rst,
  input  tac_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  tac_pkg::job_t     q_data,
  output logic              q_rd,
  input  logic              pop,
  output logic              res_valid,
  output tac_pkg::result_t  res
);
  import tac_pkg::*;

  back_state_t st, st_next;
  logic [STEP_W-1:0] step;

  logic [ID_W-1:0]          id_r [SLOTS];
  logic signed [XY_W-1:0]   xr [SLOTS];
  logic signed [XY_W-1:0]   yr [SLOTS];
  logic signed [RW_W-1:0]   rw [SLOTS];
  logic signed [D_W-1:0]    diff [SLOTS];
  logic signed [PROD_W-1:0] pr0, pr1;
  logic signed [ACC_W-1:0]  acc;

  logic signed [MUL_W-1:0]  a0, b0, a1, b1;
  logic signed [MUL_W-1:0]  dhi [SLOTS];
  logic signed [MUL_W-1:0]  dlo [SLOTS];
  logic signed [RW_W-1:0]   rw_small [SLOTS];
  logic signed [RW_W-1:0]   rw_large [SLOTS];
  logic signed [D_W-1:0]    mdiff;
  logic signed [ACC_W-1:0]  term;
  logic                     all_small, emit_go;
  logic                     cw, back, culled;

  // next state
  always_comb begin
    st_next = st;
    case (st)
      BK_IDLE: if (!q_empty) st_next = BK_CALC;
      BK_CALC: if (step == LAST_STEP) st_next = BK_EMIT;
      BK_EMIT: if (!res_valid || pop) st_next = BK_IDLE;
      default: st_next = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_rd    = (st == BK_IDLE) && !q_empty;
    emit_go = (st == BK_EMIT) && (!res_valid || pop);
  end

  // rounding of a fresh triangle, w scaled when any w is large
  always_comb begin
    logic signed [COORD_W-1:0] wv;
    logic signed [XY_W-1:0]    rs, rl;
    all_small = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      wv = $signed(q_data.v[i].w);
      rs = rnd4(wv);
      rl = rnd4(wv >>> W_SCALE_SHIFT);
      rw_small[i] = RW_W'(rs);
      rw_large[i] = RW_W'(rl);
      if (!((q_data.v[i].w & W_BIG_MASK) == '0 ||
            (q_data.v[i].w & W_BIG_MASK) == W_BIG_MASK)) begin
        all_small = 1'b0;
      end
    end
  end

  // split each difference into a signed high and an unsigned low part
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      dhi[i] = MUL_W'(diff[i] >>> LO_W);
      dlo[i] = MUL_W'($signed({1'b0, diff[i][LO_W-1:0]}));
    end
  end

  // multiplier operands per step
  always_comb begin
    a0 = '0; b0 = '0; a1 = '0; b1 = '0;
    case (step)
      3'd0: begin
        a0 = MUL_W'(xr[1]); b0 = MUL_W'(yr[2]); a1 = MUL_W'(xr[2]); b1 = MUL_W'(yr[1]);
      end
      3'd1: begin
        a0 = MUL_W'(xr[0]); b0 = MUL_W'(yr[2]); a1 = MUL_W'(xr[2]); b1 = MUL_W'(yr[0]);
      end
      3'd2: begin
        a0 = MUL_W'(xr[0]); b0 = MUL_W'(yr[1]); a1 = MUL_W'(xr[1]); b1 = MUL_W'(yr[0]);
      end
      3'd3: begin
        a0 = MUL_W'(rw[0]); b0 = dhi[0]; a1 = MUL_W'(rw[0]); b1 = dlo[0];
      end
      3'd4: begin
        a0 = MUL_W'(rw[1]); b0 = dhi[1]; a1 = MUL_W'(rw[1]); b1 = dlo[1];
      end
      3'd5: begin
        a0 = MUL_W'(rw[2]); b0 = dhi[2]; a1 = MUL_W'(rw[2]); b1 = dlo[2];
      end
      default: begin
        a0 = '0; b0 = '0; a1 = '0; b1 = '0;
      end
    endcase
  end

  // product differences and weighted terms from the product registers
  always_comb begin
    mdiff = D_W'((pr0 >>> FRACTION_BITS) - (pr1 >>> FRACTION_BITS));
    term  = (ACC_W'(pr0) <<< LO_W) + ACC_W'(pr1);
  end

  // facing and culling from the determinant sign
  always_comb begin
    cw   = acc[ACC_W-1];
    back = cw ^ cfg.clockwise_front;
    culled = 1'b0;
    if (cfg.cull_enable) begin
      case (cfg.cull_face)
        CULL_BOTH:  culled = 1'b1;
        CULL_FRONT: culled = !back;
        default:    culled = back;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= BK_IDLE;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == BK_CALC) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
      if (emit_go) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_rd) begin
      for (int i = 0; i < SLOTS; i++) begin
        id_r[i] <= q_data.v[i].id;
        xr[i]   <= rnd4($signed(q_data.v[i].x));
        yr[i]   <= rnd4($signed(q_data.v[i].y));
        rw[i]   <= all_small ? rw_small[i] : rw_large[i];
      end
    end
    if (st == BK_CALC) begin
      pr0 <= a0 * b0;
      pr1 <= a1 * b1;
      case (step)
        3'd1:    diff[0] <= mdiff;
        3'd2:    diff[1] <= mdiff;
        3'd3:    diff[2] <= mdiff;
        3'd4:    acc <= term;
        3'd5:    acc <= acc - term;
        3'd6:    acc <= acc + term;
        default: acc <= acc;
      endcase
    end
    if (emit_go) begin
      res.first_id        <= id_r[0];
      res.second_id       <= cw ? id_r[2] : id_r[1];
      res.third_id        <= cw ? id_r[1] : id_r[2];
      res.is_clockwise    <= cw;
      res.is_back_face    <= back;
      res.is_culled       <= culled;
      res.use_back_colour <= cfg.two_sided_light && back;
    end
  end

endmodule

// ===== design/tac_checker.sv =====
// ----------------------------------------------------------------------------
// tac_checker: port-level checks for the triangle assembly and cull unit
// Watches the top-level ports only; attached by the bind at the foot.
// ----------------------------------------------------------------------------
module tac_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                push,
  input logic                                full,
  input logic                                start_primitive,
  input logic [tac_pkg::ID_W-1:0]            vertex_id,
  input logic signed [tac_pkg::COORD_W-1:0]  clip_x,
  input logic signed [tac_pkg::COORD_W-1:0]  clip_y,
  input logic signed [tac_pkg::COORD_W-1:0]  clip_w,
  input logic                                empty,
  input logic                                pop,
  input logic [tac_pkg::ID_W-1:0]            first_id,
  input logic [tac_pkg::ID_W-1:0]            second_id,
  input logic [tac_pkg::ID_W-1:0]            third_id,
  input logic                                is_clockwise,
  input logic                                is_back_face,
  input logic                                is_culled,
  input logic                                use_back_colour,
  input logic                                cfg_write,
  input logic [tac_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input logic [tac_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tac_pkg::*;

  logic cull_seen;

  // track the cull enable as written on the config port
  always_ff @(posedge clk) begin
    if (rst) begin
      cull_seen <= 1'b0;
    end else if (cfg_write && cfg_index == CFG_CULL_ENABLE) begin
      cull_seen <= cfg_data[0];
    end
  end

  // reset leaves no result pending and room for vertices
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or full flag set after reset");

  // a waiting result stays, with its ids and cull flag unchanged, until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(first_id) && $stable(second_id) &&
                          $stable(third_id) && $stable(is_culled)))
    else $error("stalled result changed");

  // back colour only ever on a back face
  a_back_colour: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (!use_back_colour || is_back_face))
    else $error("back colour on a front face");

  // no triangle is marked culled while culling is off
  a_cull_off: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_culled) |-> cull_seen)
    else $error("triangle culled with culling disabled");

endmodule

bind triangle_assembly_and_cull_unit tac_checker u_checker (.*);
